// ===== src/epoch_to_calendar_macros.svh =====
// assertion macros for the epoch to calendar converter
// used by the top level; assumes signals named clock and reset in scope
`ifndef EPOCH_TO_CALENDAR_MACROS_SVH
`define EPOCH_TO_CALENDAR_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define ECAL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// next-cycle implication that also holds across reset
`define ECAL_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) cond |=> conseq) \
      else $error(msg);
`else
`define ECAL_ASSERT(label, prop, msg)
`define ECAL_ASSERT_NEXT(label, cond, conseq, msg)
`endif
`endif

// ===== src/ecal_pkg.sv =====
// shared types, widths and conversion constants for the epoch to calendar block
// no dependencies
`default_nettype none

package ecal_pkg;

   // pipeline stages
   localparam int NUM_STAGES = 6;
   localparam int STG_SUM    = 0;
   localparam int STG_DAYS   = 1;
   localparam int STG_SPLIT  = 2;
   localparam int STG_HOUR   = 3;
   localparam int STG_YEAR   = 4;
   localparam int STG_OUT    = 5;

   // field widths
   localparam int EPOCH_W  = 32;
   localparam int OFFSET_W = 17;
   localparam int SEC_W    = 6;
   localparam int MIN_W    = 6;
   localparam int HOUR_W   = 5;
   localparam int WDAY_W   = 3;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int MDAY_W   = 5;

   // internal widths
   localparam int DAYS_W = 16;   // days since 1970, below 49711
   localparam int SOD_W  = 17;   // second of the day
   localparam int CYC_W  = 6;    // four-year cycles, up to 34
   localparam int REM_W  = 11;   // day within the current four-year span
   localparam int WQ_W   = 13;   // whole weeks
   localparam int MS_W   = 12;   // second within the hour
   localparam int DOY_W  = 9;    // day within the year
   localparam int YIC_W  = 2;    // year within the cycle

   // days = (t >> 7) * DAY_RECIP >> DAY_SHIFT, exact for every 32-bit t
   localparam int                  DAY_PRESHIFT = 7;
   localparam int                  DAY_RECIP_W  = 26;
   localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 26'd50903317;
   localparam int                  DAY_SHIFT    = 35;
   localparam logic [SOD_W-1:0]    SECS_PER_DAY = 17'd86400;

   // reciprocals for the narrower divisions
   localparam int                  CYC_RECIP_W  = 17;
   localparam logic [CYC_RECIP_W-1:0] CYC_RECIP = 17'd91868;
   localparam int                  CYC_SHIFT    = 27;
   localparam logic [REM_W-1:0]    DAYS_PER_CYCLE = 11'd1461;

   localparam int                  HOUR_RECIP_W = 18;
   localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = 18'd149131;
   localparam int                  HOUR_SHIFT   = 29;
   localparam logic [MS_W-1:0]     SECS_PER_HOUR = 12'd3600;

   localparam int                  WEEK_RECIP_W = 17;
   localparam logic [WEEK_RECIP_W-1:0] WEEK_RECIP = 17'd74899;
   localparam int                  WEEK_SHIFT   = 19;
   localparam logic [WDAY_W:0]     DAYS_PER_WEEK = 4'd7;
   localparam logic [WDAY_W:0]     EPOCH_WEEKDAY = 4'd4;   // 1970-01-01 was a Thursday

   localparam int                  MIN_RECIP_W  = 13;
   localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = 13'd4370;
   localparam int                  MIN_SHIFT    = 18;
   localparam logic [MIN_W-1:0]    SECS_PER_MIN = 6'd60;

   localparam logic [REM_W-1:0]    LEAP_YEAR_END = 11'd1096;
   localparam logic [REM_W-1:0]    DAYS_PER_YEAR = 11'd365;
   localparam logic [YEAR_W-1:0]   EPOCH_YEAR    = 12'd1970;
   localparam logic [YIC_W-1:0]    LEAP_YIC      = 2'd2;

   // first day of each month in a common year, from lengths
   // 31 28 31 30 31 30 31 31 30 31 30 31
   localparam int MONTHS = 12;
   localparam logic [DOY_W-1:0] MONTH_START [MONTHS] = '{
      9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };
   localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd2;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

   typedef struct packed {
      logic [SOD_W-1:0]  sod;
      logic [DAYS_W-1:0] days;
      logic [CYC_W-1:0]  cyc;
   } split_type;

   typedef struct packed {
      logic [SEC_W-1:0]   second;
      logic [MIN_W-1:0]   minute;
      logic [HOUR_W-1:0]  hour;
      logic [WDAY_W-1:0]  weekday;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [MDAY_W-1:0]  day_of_month;
   } result_type;

   // first day of month idx (0 based) in the year, leap adds February 29
   function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] idx,
                                                    input logic leap);
      logic [DOY_W-1:0] base;
      base = (idx < MONTHS) ? MONTH_START[idx] : '0;
      return base + {{(DOY_W-1){1'b0}}, (leap && idx >= MONTH_MARCH)};
   endfunction

endpackage

`default_nettype wire

// ===== src/ecal_channels.sv =====
// request and response channel interfaces of the epoch to calendar block
// depends on ecal_pkg
`default_nettype none

interface ecal_req_if;
   logic                         valid;
   logic                         ready;
   logic [ecal_pkg::EPOCH_W-1:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ecal_pkg::SEC_W-1:0]   second;
   logic [ecal_pkg::MIN_W-1:0]   minute;
   logic [ecal_pkg::HOUR_W-1:0]  hour;
   logic [ecal_pkg::WDAY_W-1:0]  weekday;
   logic [ecal_pkg::YEAR_W-1:0]  year;
   logic [ecal_pkg::MONTH_W-1:0] month;
   logic [ecal_pkg::MDAY_W-1:0]  day_of_month;

   modport source (output valid, output second, output minute, output hour,
                   output weekday, output year, output month, output day_of_month,
                   input ready);
   modport sink   (input valid, input second, input minute, input hour,
                   input weekday, input year, input month, input day_of_month,
                   output ready);
endinterface

`default_nettype wire

// ===== src/ecal_pipe_ctrl.sv =====
// per-stage valid bits and load enables for the conversion pipeline
// depends on ecal_pkg
`default_nettype none

module ecal_pipe_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      ecal_pkg::pipe_ctl_type ctl
);

   localparam int NS = ecal_pkg::NUM_STAGES;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] up_valid;
   logic [NS:0]   ready_chain;

   assign up_valid = {valid_ff[NS-2:0], in_valid};

   // a stage may take a new item when empty or when its item moves on
   always_comb begin
      ready_chain[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         ready_chain[k] = !valid_ff[k] || ready_chain[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         valid_in[k] = ready_chain[k] ? up_valid[k] : valid_ff[k];
         ctl.load[k] = ready_chain[k] && up_valid[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready_chain[0];
   assign out_valid = valid_ff[NS-1];

endmodule

`default_nettype wire

// ===== src/ecal_day_split.sv =====
// front stages: zone offset add, whole days, second of day and four-year cycle
// depends on ecal_pkg
`default_nettype none

module ecal_day_split (
   input  wire logic                                clock,
   input  wire ecal_pkg::pipe_ctl_type              ctl,
   input  wire logic [ecal_pkg::EPOCH_W-1:0]        epoch_seconds,
   input  wire logic [ecal_pkg::OFFSET_W-1:0]       zone_offset,
   output      ecal_pkg::split_type                 split
);

   localparam int EW      = ecal_pkg::EPOCH_W;
   localparam int OW      = ecal_pkg::OFFSET_W;
   localparam int DW      = ecal_pkg::DAYS_W;
   localparam int SW      = ecal_pkg::SOD_W;
   localparam int DAYP_W  = EW - ecal_pkg::DAY_PRESHIFT + ecal_pkg::DAY_RECIP_W;
   localparam int CYCP_W  = DW + ecal_pkg::CYC_RECIP_W;
   localparam int DSEC_W  = DW + SW;

   logic [EW-1:0]     t_ff, t_in;
   logic [DW-1:0]     days_ff, days_in;
   logic [SW-1:0]     tlo_ff, tlo_in;
   logic [DAYP_W-1:0] days_prod;
   logic [DSEC_W-1:0] day_secs;
   logic [CYCP_W-1:0] cyc_prod;
   ecal_pkg::split_type split_ff, split_in;

   // offset is sign extended, sum wraps modulo 2^32
   assign t_in = epoch_seconds + {{(EW-OW){zone_offset[OW-1]}}, zone_offset};

   // divide by 86400 as divide by 128 then reciprocal of 675
   assign days_prod = DAYP_W'(t_ff[EW-1:ecal_pkg::DAY_PRESHIFT])
                      * DAYP_W'(ecal_pkg::DAY_RECIP);
   assign days_in   = days_prod[ecal_pkg::DAY_SHIFT +: DW];
   assign tlo_in    = t_ff[SW-1:0];

   // second of day only needs the low bits of the remainder
   assign day_secs      = DSEC_W'(days_ff) * DSEC_W'(ecal_pkg::SECS_PER_DAY);
   assign split_in.sod  = tlo_ff - day_secs[SW-1:0];
   assign split_in.days = days_ff;
   assign cyc_prod      = CYCP_W'(days_ff) * CYCP_W'(ecal_pkg::CYC_RECIP);
   assign split_in.cyc  = cyc_prod[ecal_pkg::CYC_SHIFT +: ecal_pkg::CYC_W];

   always_ff @(posedge clock) begin
      if (ctl.load[ecal_pkg::STG_SUM]) begin
         t_ff <= t_in;
      end
      if (ctl.load[ecal_pkg::STG_DAYS]) begin
         days_ff <= days_in;
         tlo_ff  <= tlo_in;
      end
      if (ctl.load[ecal_pkg::STG_SPLIT]) begin
         split_ff <= split_in;
      end
   end

   assign split = split_ff;

endmodule

`default_nettype wire

// ===== src/ecal_calendar.sv =====
// back stages: hour, weekday, year, month, day, minute and second
// depends on ecal_pkg
`default_nettype none

module ecal_calendar (
   input  wire logic                   clock,
   input  wire ecal_pkg::pipe_ctl_type ctl,
   input  wire ecal_pkg::split_type    split,
   output      ecal_pkg::result_type   result
);

   localparam int DW     = ecal_pkg::DAYS_W;
   localparam int SW     = ecal_pkg::SOD_W;
   localparam int RW     = ecal_pkg::REM_W;
   localparam int MW     = ecal_pkg::MS_W;
   localparam int YW     = ecal_pkg::YEAR_W;
   localparam int DYW    = ecal_pkg::DOY_W;
   localparam int WW     = ecal_pkg::WDAY_W;
   localparam int MOW    = ecal_pkg::MONTH_W;
   localparam int HOURP_W = SW + ecal_pkg::HOUR_RECIP_W;
   localparam int WEEKP_W = DW + ecal_pkg::WEEK_RECIP_W;
   localparam int MINP_W  = MW + ecal_pkg::MIN_RECIP_W;

   // hour stage
   logic [HOURP_W-1:0]            hour_prod;
   logic [WEEKP_W-1:0]            week_prod;
   logic [DW-1:0]                 cyc_base, rem_diff;
   logic [ecal_pkg::HOUR_W-1:0]   hour4_ff, hour4_in;
   logic [ecal_pkg::WQ_W-1:0]     wq4_ff, wq4_in;
   logic [RW-1:0]                 rem4_ff, rem4_in;
   logic [SW-1:0]                 sod4_ff;
   logic [DW-1:0]                 days4_ff;
   logic [ecal_pkg::CYC_W-1:0]    cyc4_ff;

   // year stage
   logic [SW-1:0]                 hour_secs, ms_diff;
   logic [DW-1:0]                 week_base, wk_diff;
   logic [WW:0]                   wk_sum;
   logic [RW-1:0]                 doy_diff;
   logic [ecal_pkg::YIC_W-1:0]    yic;
   logic [MW-1:0]                 ms5_ff, ms5_in;
   logic [WW-1:0]                 wday5_ff, wday5_in;
   logic [YW-1:0]                 year5_ff, year5_in;
   logic [DYW-1:0]                doy5_ff, doy5_in;
   logic                          leap5_ff, leap5_in;
   logic [ecal_pkg::HOUR_W-1:0]   hour5_ff;

   // output stage
   logic [MINP_W-1:0]             min_prod;
   logic [ecal_pkg::MIN_W-1:0]    minute;
   logic [ecal_pkg::MIN_W+ecal_pkg::SEC_W-1:0] min_secs;
   logic [MW-1:0]                 sec_diff;
   logic [MOW-1:0]                midx;
   logic [DYW-1:0]                mstart, mday_diff;
   ecal_pkg::result_type          result_ff, result_in;

   // ---- hour, whole weeks, day within the cycle
   assign hour_prod = HOURP_W'(split.sod) * HOURP_W'(ecal_pkg::HOUR_RECIP);
   assign hour4_in  = hour_prod[ecal_pkg::HOUR_SHIFT +: ecal_pkg::HOUR_W];
   assign week_prod = WEEKP_W'(split.days) * WEEKP_W'(ecal_pkg::WEEK_RECIP);
   assign wq4_in    = week_prod[ecal_pkg::WEEK_SHIFT +: ecal_pkg::WQ_W];
   assign cyc_base  = DW'(split.cyc) * DW'(ecal_pkg::DAYS_PER_CYCLE);
   assign rem_diff  = split.days - cyc_base;
   assign rem4_in   = rem_diff[RW-1:0];

   // ---- second of hour, weekday, year within cycle
   assign hour_secs = SW'(hour4_ff) * SW'(ecal_pkg::SECS_PER_HOUR);
   assign ms_diff   = sod4_ff - hour_secs;
   assign ms5_in    = ms_diff[MW-1:0];

   assign week_base = DW'(wq4_ff) * DW'(ecal_pkg::DAYS_PER_WEEK);
   assign wk_diff   = days4_ff - week_base;
   assign wk_sum    = {1'b0, wk_diff[WW-1:0]} + ecal_pkg::EPOCH_WEEKDAY;

   always_comb begin
      if (wk_sum >= ecal_pkg::DAYS_PER_WEEK) begin
         wday5_in = wk_sum[WW-1:0] - ecal_pkg::DAYS_PER_WEEK[WW-1:0];
      end else begin
         wday5_in = wk_sum[WW-1:0];
      end
   end

   // third year of each cycle is the leap one and keeps its last day
   always_comb begin
      priority if (rem4_ff >= ecal_pkg::LEAP_YEAR_END) begin
         yic      = 2'd3;
         doy_diff = rem4_ff - ecal_pkg::LEAP_YEAR_END;
      end else if (rem4_ff >= {ecal_pkg::DAYS_PER_YEAR[RW-2:0], 1'b0}) begin
         yic      = 2'd2;
         doy_diff = rem4_ff - {ecal_pkg::DAYS_PER_YEAR[RW-2:0], 1'b0};
      end else if (rem4_ff >= ecal_pkg::DAYS_PER_YEAR) begin
         yic      = 2'd1;
         doy_diff = rem4_ff - ecal_pkg::DAYS_PER_YEAR;
      end else begin
         yic      = 2'd0;
         doy_diff = rem4_ff;
      end
   end

   assign doy5_in  = doy_diff[DYW-1:0];
   assign leap5_in = (yic == ecal_pkg::LEAP_YIC);
   assign year5_in = ecal_pkg::EPOCH_YEAR + YW'({cyc4_ff, 2'b00}) + YW'(yic);

   // ---- minute, second, month and day
   assign min_prod = MINP_W'(ms5_ff) * MINP_W'(ecal_pkg::MIN_RECIP);
   assign minute   = min_prod[ecal_pkg::MIN_SHIFT +: ecal_pkg::MIN_W];
   assign min_secs = {minute, 6'b0} - {4'b0, minute, 2'b0};
   assign sec_diff = ms5_ff - min_secs;

   // month starts rise, so the count of passed starts is the month index
   always_comb begin
      midx = '0;
      for (int k = 1; k < ecal_pkg::MONTHS; k++) begin
         if (doy5_ff >= ecal_pkg::month_start(MOW'(k), leap5_ff)) begin
            midx = midx + 1'b1;
         end
      end
   end

   assign mstart    = ecal_pkg::month_start(midx, leap5_ff);
   assign mday_diff = doy5_ff - mstart + 1'b1;

   always_comb begin
      result_in.second       = sec_diff[ecal_pkg::SEC_W-1:0];
      result_in.minute       = minute;
      result_in.hour         = hour5_ff;
      result_in.weekday      = wday5_ff;
      result_in.year         = year5_ff;
      result_in.month        = midx + 1'b1;
      result_in.day_of_month = mday_diff[ecal_pkg::MDAY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ecal_pkg::STG_HOUR]) begin
         hour4_ff <= hour4_in;
         wq4_ff   <= wq4_in;
         rem4_ff  <= rem4_in;
         sod4_ff  <= split.sod;
         days4_ff <= split.days;
         cyc4_ff  <= split.cyc;
      end
      if (ctl.load[ecal_pkg::STG_YEAR]) begin
         ms5_ff   <= ms5_in;
         wday5_ff <= wday5_in;
         year5_ff <= year5_in;
         doy5_ff  <= doy5_in;
         leap5_ff <= leap5_in;
         hour5_ff <= hour4_ff;
      end
      if (ctl.load[ecal_pkg::STG_OUT]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== src/epoch_to_calendar.sv =====
// top level of the epoch to calendar converter: zone register, pipeline, checks
// depends on ecal_pkg, ecal_channels, ecal_pipe_ctrl, ecal_day_split, ecal_calendar
`default_nettype none
`include "epoch_to_calendar_macros.svh"

//  channel    direction  handshake          payload
//  req_chan   in         valid / ready      epoch_seconds
//  rsp_chan   out        valid / ready      second minute hour weekday year month day_of_month
//  csr        in         csr_we             csr_wdata (signed zone offset, seconds)
//
//  one transfer accepted per cycle while the response side keeps up; a result passes
//  through the six register stages of the reciprocal-multiply chain
//  each stage holds its item until the next one frees, so a stalled result does not
//  block requests while any stage further up is empty
//  synchronous active-high reset empties the pipeline and sets the zone offset to 0

module epoch_to_calendar (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ecal_req_if.sink                            req_chan,
   ecal_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [ecal_pkg::OFFSET_W-1:0]  csr_wdata
);

   logic [ecal_pkg::OFFSET_W-1:0] offset_ff;
   ecal_pkg::pipe_ctl_type        ctl;
   ecal_pkg::split_type           split;
   ecal_pkg::result_type          result;

   // zone offset register, any 17-bit pattern is taken as written
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_we) begin
         offset_ff <= csr_wdata;
      end
   end

   // valid bits and stage loads
   ecal_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   // offset add, days since 1970, second of day, four-year cycle
   ecal_day_split u_split (
      .clock         (clock),
      .ctl           (ctl),
      .epoch_seconds (req_chan.epoch_seconds),
      .zone_offset   (offset_ff),
      .split         (split)
   );

   // time of day, weekday and date; last stage is the result register
   ecal_calendar u_cal (
      .clock  (clock),
      .ctl    (ctl),
      .split  (split),
      .result (result)
   );

   assign rsp_chan.second       = result.second;
   assign rsp_chan.minute       = result.minute;
   assign rsp_chan.hour         = result.hour;
   assign rsp_chan.weekday      = result.weekday;
   assign rsp_chan.year         = result.year;
   assign rsp_chan.month        = result.month;
   assign rsp_chan.day_of_month = result.day_of_month;

   // a shown result always carries a legal time of day and weekday
   `ECAL_ASSERT(a_time_range, rsp_chan.valid |-> (rsp_chan.second < 6'd60 && rsp_chan.minute < 6'd60 && rsp_chan.hour < 5'd24 && rsp_chan.weekday < 3'd7), "time of day out of range")

   // month lies in 1 to 12, day is at least 1, and february has no day past 29
   `ECAL_ASSERT(a_date_range, rsp_chan.valid |-> (rsp_chan.month >= 4'd1 && rsp_chan.month <= 4'd12 && rsp_chan.day_of_month >= 5'd1 && !(rsp_chan.month == 4'd2 && rsp_chan.day_of_month > 5'd29)), "date out of range")

   // a draining output never holds off requests
   `ECAL_ASSERT(a_no_block, rsp_chan.ready |-> req_chan.ready, "request stalled while response side drains")

   // reset leaves the pipeline empty and open
   `ECAL_ASSERT_NEXT(a_reset_empty, reset, (!rsp_chan.valid && req_chan.ready), "pipeline not empty after reset")

endmodule

`default_nettype wire

// ===== bench/epoch_to_calendar_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for epoch_to_calendar: a directed list of dates, then random timestamps
// under several zone offsets, each response checked against a date listed or computed here
// depends on ecal_pkg, ecal_channels and epoch_to_calendar

module epoch_to_calendar_tb;

   localparam int CLOCK_HALF   = 1;        // 2 ns period
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 1150;
   localparam int PHASES       = 8;
   localparam int PIPE_DEPTH   = 6;        // register stages, per the block header
   localparam int DRAIN_CYCLES = 4 * PIPE_DEPTH;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 20;
   localparam int PRINT_CAP    = 50;

   // calendar arithmetic
   localparam int SECS_DAY   = 86400;
   localparam int DAYS_4Y    = 1461;
   localparam int LEAP_END   = 1096;     // first day after the leap year of a cycle
   localparam int YEAR_DAYS  = 365;
   localparam int FIRST_YEAR = 1970;
   localparam int THURSDAY   = 4;        // weekday of day zero
   localparam int LAST_CYCLE = 33;       // last complete four-year cycle below 2^32 seconds
   localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // days within a four-year span where the year or month turns over
   localparam int EDGE_DAYS [15] = '{0, 30, 31, 58, 59, 364, 365, 729, 730,
                                     788, 789, 790, 1095, 1096, 1460};

   // zone offsets, as 17-bit register patterns
   localparam logic [ecal_pkg::OFFSET_W-1:0] ZONE_UTC       = '0;
   localparam logic [ecal_pkg::OFFSET_W-1:0] ZONE_EAST      = 17'd50400;
   localparam logic [ecal_pkg::OFFSET_W-1:0] ZONE_WEST      = -17'sd50400;
   localparam logic [ecal_pkg::OFFSET_W-1:0] ZONE_PLUS_ONE  = 17'd1;
   localparam logic [ecal_pkg::OFFSET_W-1:0] ZONE_MINUS_ONE = '1;
   localparam logic [ecal_pkg::OFFSET_W-1:0] ZONE_MOST_POS  = 17'h0FFFF;
   localparam logic [ecal_pkg::OFFSET_W-1:0] ZONE_MOST_NEG  = 17'h10000;

   // dates that can be read off directly
   // second, minute, hour, weekday, year, month, day
   localparam ecal_pkg::result_type EPOCH_START =
      '{6'd0, 6'd0, 5'd0, 3'd4, 12'd1970, 4'd1, 5'd1};
   localparam ecal_pkg::result_type FIRST_DAY_END =
      '{6'd59, 6'd59, 5'd23, 3'd4, 12'd1970, 4'd1, 5'd1};
   localparam ecal_pkg::result_type SECOND_DAY =
      '{6'd0, 6'd0, 5'd0, 3'd5, 12'd1970, 4'd1, 5'd2};
   // all-ones count; 2100 counted as leap puts it on february 6
   localparam ecal_pkg::result_type LAST_SECOND =
      '{6'd15, 6'd28, 5'd6, 3'd0, 12'd2106, 4'd2, 5'd6};
   localparam ecal_pkg::result_type NO_DATE = '0;

   typedef struct packed {
      logic [ecal_pkg::OFFSET_W-1:0] zone;
      logic [ecal_pkg::EPOCH_W-1:0]  epoch;
      logic                          typed;   // date column holds the answer
      ecal_pkg::result_type          date;
   } probe_row_type;

   localparam int NUM_PROBES = 24;
   localparam probe_row_type PROBES [NUM_PROBES] = '{
      // zone left at its reset value
      '{ZONE_UTC,       32'd0,          1'b1, EPOCH_START},
      '{ZONE_UTC,       32'hFFFF_FFFF,  1'b1, LAST_SECOND},
      '{ZONE_UTC,       32'd86399,      1'b1, FIRST_DAY_END},
      '{ZONE_UTC,       32'd86400,      1'b1, SECOND_DAY},
      // 1970-12-31 23:59:59 and 1971-01-01
      '{ZONE_UTC,       32'd31535999,   1'b0, NO_DATE},
      '{ZONE_UTC,       32'd31536000,   1'b0, NO_DATE},
      // 1972-02-28 last second and 1972-02-29
      '{ZONE_UTC,       32'd68169599,   1'b0, NO_DATE},
      '{ZONE_UTC,       32'd68169600,   1'b0, NO_DATE},
      // last day of the leap year stays in the leap year
      '{ZONE_UTC,       32'd94694399,   1'b0, NO_DATE},
      '{ZONE_UTC,       32'd94694400,   1'b0, NO_DATE},
      // end of the first cycle
      '{ZONE_UTC,       32'd126230399,  1'b0, NO_DATE},
      '{ZONE_UTC,       32'd126230400,  1'b0, NO_DATE},
      // 2100 treated as leap: february 28 end and february 29
      '{ZONE_UTC,       32'd4107542399, 1'b0, NO_DATE},
      '{ZONE_UTC,       32'd4107542400, 1'b0, NO_DATE},
      // sum wraps in both directions
      '{ZONE_MINUS_ONE, 32'd0,          1'b1, LAST_SECOND},
      '{ZONE_PLUS_ONE,  32'hFFFF_FFFF,  1'b1, EPOCH_START},
      '{ZONE_EAST,      32'd0,          1'b0, NO_DATE},
      '{ZONE_EAST,      32'hFFFF_3CAF,  1'b0, NO_DATE},
      '{ZONE_WEST,      32'd0,          1'b0, NO_DATE},
      '{ZONE_WEST,      32'd50399,      1'b1, LAST_SECOND},
      // offsets beyond the nominal range are used as given
      '{ZONE_MOST_NEG,  32'h5555_5555,  1'b0, NO_DATE},
      '{ZONE_MOST_POS,  32'hAAAA_AAAA,  1'b0, NO_DATE},
      '{ZONE_MOST_POS,  32'd0,          1'b0, NO_DATE},
      '{ZONE_UTC,       32'h8000_0000,  1'b0, NO_DATE}
   };

   typedef struct {
      logic [ecal_pkg::EPOCH_W-1:0] epoch;
      ecal_pkg::result_type         date;
   } pending_date_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ecal_pkg::OFFSET_W-1:0] csr_wdata;

   ecal_req_if req_chan ();
   ecal_rsp_if rsp_chan ();

   epoch_to_calendar dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   pending_date_type              pending_dates [$];   // dates still owed by the block
   logic [ecal_pkg::OFFSET_W-1:0] zone_now;            // bench copy of the zone register
   bit                            calm;                // both sides stop idling
   int                            mismatch_count;
   int                            cycle_count;

   // calendar date of a timestamp shifted by the zone offset
   function automatic ecal_pkg::result_type epoch_to_date(
         input logic [ecal_pkg::EPOCH_W-1:0] epoch,
         input logic [ecal_pkg::OFFSET_W-1:0] zone);
      ecal_pkg::result_type date;
      logic [31:0] wall;
      int unsigned secs, days, day_of_cycle, year_of_cycle, mon, mon_len;
      // sign-extend the offset and let the sum wrap at 32 bits
      wall = epoch + {{(32 - ecal_pkg::OFFSET_W){zone[ecal_pkg::OFFSET_W-1]}}, zone};
      secs = wall;
      date.second = 6'(secs % 60);
      secs = secs / 60;
      date.minute = 6'(secs % 60);
      secs = secs / 60;
      date.hour = 5'(secs % 24);
      days = secs / 24;
      date.weekday = 3'((days + THURSDAY) % 7);
      // third year of each four-year cycle is leap and runs to day 1095
      day_of_cycle = days % DAYS_4Y;
      if (day_of_cycle >= LEAP_END) begin
         year_of_cycle = 3;
         day_of_cycle = day_of_cycle - LEAP_END;
      end else begin
         year_of_cycle = day_of_cycle / YEAR_DAYS;
         if (year_of_cycle > 2) begin
            year_of_cycle = 2;
         end
         day_of_cycle = day_of_cycle - year_of_cycle * YEAR_DAYS;
      end
      date.year = 12'(FIRST_YEAR + (days / DAYS_4Y) * 4 + year_of_cycle);
      // walk the month lengths, december takes whatever is left
      mon = 0;
      mon_len = MONTH_LEN[0];
      while (mon < 11 && day_of_cycle >= mon_len) begin
         day_of_cycle = day_of_cycle - mon_len;
         mon = mon + 1;
         mon_len = MONTH_LEN[mon] + ((mon == 1 && year_of_cycle == 2) ? 1 : 0);
      end
      date.month = 4'(mon + 1);
      date.day_of_month = 5'(day_of_cycle + 1);
      return date;
   endfunction

   // random timestamp: plain 32-bit values, day and cycle edges, both ends of the range
   function automatic logic [ecal_pkg::EPOCH_W-1:0] pick_epoch();
      int unsigned day, sec;
      case ($urandom_range(4))
         0, 1: begin
            return $urandom;
         end
         2: begin
            day = $urandom_range(49709);
            case ($urandom_range(3))
               0: sec = 0;
               1: sec = SECS_DAY - 1;
               default: sec = $urandom_range(SECS_DAY - 1);
            endcase
            return day * SECS_DAY + sec;
         end
         3: begin
            if ($urandom_range(1)) begin
               day = EDGE_DAYS[$urandom_range(14)];
            end else begin
               day = $urandom_range(DAYS_4Y - 1);
            end
            day = $urandom_range(LAST_CYCLE) * DAYS_4Y + day;
            return day * SECS_DAY + $urandom_range(SECS_DAY - 1);
         end
         default: begin
            if ($urandom_range(1)) begin
               return $urandom_range(999);
            end
            return 32'hFFFF_FFFF - $urandom_range(999);
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input logic [31:0] epoch, input string name,
                              input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("epoch %0d %s got %0d want %0d", epoch, name, got, want));
      end
   endtask

   // one request transfer, with random idle cycles ahead of it unless calm; valid stays high after
   task automatic send_epoch(input logic [ecal_pkg::EPOCH_W-1:0] epoch,
                             input ecal_pkg::result_type date);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.epoch_seconds <= epoch;
      do @(posedge clock); while (!req_chan.ready);
      pending_dates.push_back('{epoch, date});
   endtask

   // zone write only once the block holds nothing
   task automatic set_zone(input logic [ecal_pkg::OFFSET_W-1:0] zone);
      req_chan.valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= zone;
      @(posedge clock);
      csr_we <= 1'b0;
      zone_now = zone;
   endtask

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // response side: ready drops about 20 percent of the time unless calm
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // every response transfer is matched with the oldest pending date
   always @(posedge clock) begin
      pending_date_type want;
      ecal_pkg::result_type seen;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{rsp_chan.second, rsp_chan.minute, rsp_chan.hour, rsp_chan.weekday,
                  rsp_chan.year, rsp_chan.month, rsp_chan.day_of_month};
         if (pending_dates.size() == 0) begin
            flag_mismatch("response transfer with no request pending");
         end else begin
            want = pending_dates.pop_front();
            check_field(want.epoch, "second", seen.second, want.date.second);
            check_field(want.epoch, "minute", seen.minute, want.date.minute);
            check_field(want.epoch, "hour", seen.hour, want.date.hour);
            check_field(want.epoch, "weekday", seen.weekday, want.date.weekday);
            check_field(want.epoch, "year", seen.year, want.date.year);
            check_field(want.epoch, "month", seen.month, want.date.month);
            check_field(want.epoch, "day_of_month", seen.day_of_month,
                        want.date.day_of_month);
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      do begin
         @(posedge clock);
         cycle_count++;
      end while (cycle_count < CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int z;
      int per_phase;
      logic [ecal_pkg::OFFSET_W-1:0] next_zone;
      logic [ecal_pkg::EPOCH_W-1:0]  epoch;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.epoch_seconds = '0;
      zone_now = ZONE_UTC;
      calm = 1'b0;
      mismatch_count = 0;
      per_phase = RANDOM_ITEMS / PHASES;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed list, zone changes only between drained phases
      for (int i = 0; i < NUM_PROBES; i++) begin
         if (PROBES[i].zone != zone_now) begin
            set_zone(PROBES[i].zone);
         end
         send_epoch(PROBES[i].epoch, PROBES[i].typed ? PROBES[i].date
                                    : epoch_to_date(PROBES[i].epoch, zone_now));
      end

      // random timestamps, one zone per phase; each zone change drains the block
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: next_zone = ZONE_EAST;
            1: next_zone = ZONE_WEST;
            2, 6: begin
               z = $urandom_range(100800) - 50400;
               next_zone = z[ecal_pkg::OFFSET_W-1:0];
            end
            5: next_zone = ZONE_UTC;
            default: begin
               z = $urandom;   // any 17-bit pattern
               next_zone = z[ecal_pkg::OFFSET_W-1:0];
            end
         endcase
         set_zone(next_zone);
         calm = (phase == 5);   // a long stretch with no idling on either side
         for (int n = 0; n < per_phase; n++) begin
            epoch = pick_epoch();
            send_epoch(epoch, epoch_to_date(epoch, zone_now));
         end
      end

      // wait for the last responses, then give stray transfers time to show up
      req_chan.valid <= 1'b0;
      calm = 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== epoch_to_calendar.f =====
+incdir+src
src/ecal_pkg.sv
src/ecal_channels.sv
src/ecal_pipe_ctrl.sv
src/ecal_day_split.sv
src/ecal_calendar.sv
src/epoch_to_calendar.sv
bench/epoch_to_calendar_tb.sv
